FILE: sv/ica_pkg.sv
// ----------------------------------------------------------------------------
// ica_pkg
// shared types, opcodes and widths for the checked 16-bit alu
// ----------------------------------------------------------------------------
package ica_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int OP_WIDTH   = 4;
    localparam int IN_BITS    = OP_WIDTH + 2 * DATA_WIDTH;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BITS   = DATA_WIDTH + 1;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
    localparam int QDEPTH     = 2;
    localparam int DIV_STAGES = DATA_WIDTH;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD   = 4'd0,
        OP_PLUS  = 4'd1,
        OP_SUB   = 4'd2,
        OP_MINUS = 4'd3,
        OP_MUL   = 4'd4,
        OP_TIMES = 4'd5,
        OP_DIV   = 4'd6,
        OP_REM   = 4'd7,
        OP_EQ    = 4'd8,
        OP_GT    = 4'd9,
        OP_AND   = 4'd10,
        OP_OR    = 4'd11,
        OP_XOR   = 4'd12,
        OP_NOT   = 4'd13,
        OP_LSHL  = 4'd14,
        OP_LSHR  = 4'd15
    } opcode_t;

    // classified item handed from front to back
    typedef struct packed {
        opcode_t               op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic                  div_err;   // zero divisor, or most-negative by -1 on a divide
        logic                  rem_unit;  // divisor is 1 or -1
        logic                  shift_big; // count above width-1
        logic                  quot_neg;
    } item_t;

endpackage

FILE: sv/ica_front.sv
// ----------------------------------------------------------------------------
// ica_front
// accepts items and classifies special cases into a registered item
// ----------------------------------------------------------------------------
module ica_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ica_pkg::OP_WIDTH-1:0]   in_op,
    input  logic [ica_pkg::DATA_WIDTH-1:0] in_a,
    input  logic [ica_pkg::DATA_WIDTH-1:0] in_b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ica_pkg::item_t             out_item
);

    localparam int W = ica_pkg::DATA_WIDTH;

    logic           valid_reg;
    ica_pkg::item_t item_reg;
    ica_pkg::item_t item_next;
    logic           b_zero;
    logic           b_one;
    logic           b_mone;
    logic           a_min;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        b_zero = (in_b == '0);
        b_one  = (in_b == W'(1));
        b_mone = (in_b == '1);
        a_min  = (in_a == {1'b1, {(W-1){1'b0}}});
        item_next.op        = ica_pkg::opcode_t'(in_op);
        item_next.a         = in_a;
        item_next.b         = in_b;
        item_next.div_err   = b_zero || (a_min && b_mone && (in_op == ica_pkg::OP_DIV));
        item_next.rem_unit  = b_one || b_mone;
        item_next.shift_big = (in_b > W'(W - 1));
        item_next.quot_neg  = in_a[W-1] ^ in_b[W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: sv/ica_queue.sv
// ----------------------------------------------------------------------------
// ica_queue
// short fifo between the classifier and the execution pipeline
// ----------------------------------------------------------------------------
module ica_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ica_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output ica_pkg::item_t out_item
);

    localparam int D  = ica_pkg::QDEPTH;
    localparam int AW = $clog2(D);

    ica_pkg::item_t mem_reg [D];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  rd_reg;
    logic [AW:0]    cnt_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (cnt_reg != (AW+1)'(D));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(D - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(D - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/ica_back.sv
// ----------------------------------------------------------------------------
// ica_back
// execution pipeline: one restoring divide step per stage, results at the end
// ----------------------------------------------------------------------------
module ica_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ica_pkg::item_t                 in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ica_pkg::DATA_WIDTH-1:0] out_value,
    output logic                           out_err
);

    localparam int W = ica_pkg::DATA_WIDTH;
    localparam int S = ica_pkg::DIV_STAGES;

    typedef struct packed {
        logic [W-1:0] value;
        logic         err;
    } res_t;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] quo; // shifts out dividend, fills with quotient bits
        logic [W-1:0] dvs;
    } div_t;

    // registers of stages 0 to S
    logic           v_reg    [S+1];
    ica_pkg::item_t it_reg   [S+1];
    res_t           r_reg    [S+1];
    div_t           d_reg    [S+1];

    logic           adv;
    res_t           r0;
    div_t           d0;
    logic [2*W-1:0] prod;
    logic [W:0]     sum;
    logic [W:0]     dif;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    div_t           dn [S];
    res_t           fin;

    // whole pipe moves together, output register is the last stage
    assign adv       = !v_reg[S] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[S];

    always_comb
    begin
        sum  = {in_item.a[W-1], in_item.a} + {in_item.b[W-1], in_item.b};
        dif  = {in_item.a[W-1], in_item.a} - {in_item.b[W-1], in_item.b};
        prod = (2*W)'($signed({{W{in_item.a[W-1]}}, in_item.a}) *
                      $signed({{W{in_item.b[W-1]}}, in_item.b}));
        ma   = in_item.a[W-1] ? W'(-in_item.a) : in_item.a;
        mb   = in_item.b[W-1] ? W'(-in_item.b) : in_item.b;
        d0.rem = '0;
        d0.quo = ma;
        d0.dvs = mb;
        r0.err = 1'b0;
        r0.value = '0;
        unique case (in_item.op)
            ica_pkg::OP_ADD:
            begin
                r0.value = sum[W-1:0];
                r0.err   = sum[W] ^ sum[W-1];
            end
            ica_pkg::OP_PLUS:  r0.value = sum[W-1:0];
            ica_pkg::OP_SUB:
            begin
                r0.value = dif[W-1:0];
                r0.err   = dif[W] ^ dif[W-1];
            end
            ica_pkg::OP_MINUS: r0.value = dif[W-1:0];
            ica_pkg::OP_MUL:
            begin
                r0.value = prod[W-1:0];
                r0.err   = (prod[2*W-1:W-1] != {(W+1){prod[W-1]}});
            end
            ica_pkg::OP_TIMES: r0.value = prod[W-1:0];
            ica_pkg::OP_DIV:   r0.err = in_item.div_err;
            ica_pkg::OP_REM:   r0.err = in_item.div_err;
            ica_pkg::OP_EQ:    r0.value = W'(in_item.a == in_item.b);
            ica_pkg::OP_GT:    r0.value = W'($signed(in_item.a) > $signed(in_item.b));
            ica_pkg::OP_AND:   r0.value = in_item.a & in_item.b;
            ica_pkg::OP_OR:    r0.value = in_item.a | in_item.b;
            ica_pkg::OP_XOR:   r0.value = in_item.a ^ in_item.b;
            ica_pkg::OP_NOT:   r0.value = ~in_item.a;
            ica_pkg::OP_LSHL:
                r0.value = in_item.shift_big ? '0 : in_item.a << in_item.b[$clog2(W)-1:0];
            ica_pkg::OP_LSHR:
                r0.value = in_item.shift_big ? '0 : in_item.a >> in_item.b[$clog2(W)-1:0];
            default:           r0.value = '0;
        endcase
    end

    // one restoring step per stage
    always_comb
    begin
        for (int i = 0; i < S; i++)
        begin
            logic [W:0] trial;
            trial = {d_reg[i].rem, d_reg[i].quo[W-1]} - {1'b0, d_reg[i].dvs};
            dn[i].dvs = d_reg[i].dvs;
            if (!trial[W])
            begin
                dn[i].rem = trial[W-1:0];
                dn[i].quo = {d_reg[i].quo[W-2:0], 1'b1};
            end
            else
            begin
                dn[i].rem = {d_reg[i].rem[W-2:0], d_reg[i].quo[W-1]};
                dn[i].quo = {d_reg[i].quo[W-2:0], 1'b0};
            end
        end
    end

    // final sign fix and error zeroing at the output
    always_comb
    begin
        fin = r_reg[S];
        if (it_reg[S].op == ica_pkg::OP_DIV && !r_reg[S].err)
        begin
            fin.value = it_reg[S].quot_neg ? W'(-d_reg[S].quo) : d_reg[S].quo;
        end
        else if (it_reg[S].op == ica_pkg::OP_REM && !r_reg[S].err)
        begin
            fin.value = it_reg[S].rem_unit ? '0 :
                        (it_reg[S].a[W-1] ? W'(-d_reg[S].rem) : d_reg[S].rem);
        end
        if (fin.err)
        begin
            fin.value = '0;
        end
    end

    assign out_value = fin.value;
    assign out_err   = fin.err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= S; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= S; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0] <= in_item;
            r_reg[0]  <= r0;
            d_reg[0]  <= d0;
            for (int i = 1; i <= S; i++)
            begin
                it_reg[i] <= it_reg[i-1];
                r_reg[i]  <= r_reg[i-1];
                d_reg[i]  <= dn[i-1];
            end
        end
    end

endmodule

FILE: sv/int16_checked_alu_top.sv
// ----------------------------------------------------------------------------
// int16_checked_alu_top
// checked 16-bit signed alu with overflow and divide error flag
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per transfer: tdata = opcode, operand_a,
//   operand_b from the lowest bit up. m_axis returns one result per transfer:
//   tdata = value, overflow_error.
//   a classifier register takes the item, a two-entry queue decouples it from
//   the execution pipeline, which runs one divide step per stage for all ops.
//   throughput: one transfer per cycle on both sides when the receiver keeps
//   m_axis_tready high.
//   path: an accepted item passes the classifier register, the queue, stage 0
//   and the divide stages to the output register, the same for every opcode.
//   the sixteen restoring divide stages set the latency.
//   stall: when m_axis_tready drops the pipeline holds, the queue fills and
//   s_axis_tready falls; no result is lost or repeated.
//   reset: rst_n asynchronously empties all stages; nothing else is kept.
// ----------------------------------------------------------------------------
module int16_checked_alu_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ica_pkg::IN_BYTES*8-1:0]  s_axis_tdata,  // opcode, operand_a, operand_b
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ica_pkg::OUT_BYTES*8-1:0] m_axis_tdata   // value, overflow_error
);

    localparam int W  = ica_pkg::DATA_WIDTH;
    localparam int OW = ica_pkg::OP_WIDTH;

    // front to queue
    logic           f_valid;
    logic           f_ready;
    ica_pkg::item_t f_item;
    // queue to back
    logic           q_valid;
    logic           q_ready;
    ica_pkg::item_t q_item;
    logic [W-1:0]   value;
    logic           err;

    ica_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tdata[OW-1:0]),
        .in_a      (s_axis_tdata[OW+W-1:OW]),
        .in_b      (s_axis_tdata[OW+2*W-1:OW+W]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    ica_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    ica_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (value),
        .out_err   (err)
    );

    // zero padding up to whole bytes
    assign m_axis_tdata = {{(ica_pkg::OUT_BYTES*8-W-1){1'b0}}, err, value};

`ifndef NO_ASSERTIONS
    // an error always comes with a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[W] |-> m_axis_tdata[W-1:0] == '0)
        else $error("error result with nonzero value");

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a full queue always offers an item to the pipeline
    a_q_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !f_ready |-> q_valid)
        else $error("queue full without offering an item");
`endif

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking regression for the checked 16-bit alu
// ----------------------------------------------------------------------------
// a queue of operations feeds a falling-edge driver on s_axis; a rising-edge
// monitor compares every m_axis transfer with the oldest predicted result.
// the run steps through idle phases on both sides and a long receiver hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DATA_WIDTH   = ica_pkg::DATA_WIDTH;
    localparam int IN_BITS      = ica_pkg::IN_BITS;
    localparam int IN_BYTES     = ica_pkg::IN_BYTES;
    localparam int OUT_BYTES    = ica_pkg::OUT_BYTES;

    typedef struct packed {
        ica_pkg::opcode_t      op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } alu_op_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  err;
    } alu_res_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_BYTES*8-1:0]     s_axis_tdata;   // opcode, operand_a, operand_b
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_BYTES*8-1:0]    m_axis_tdata;   // value, overflow_error

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_cycles;
    int       cycle_count;
    int       errors;
    int       results_seen;
    int       ops_sent;
    logic     in_done;

    int16_checked_alu_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // predicted result of one alu operation
    function automatic alu_res_t compute_alu(alu_op_t t);
        logic signed [DATA_WIDTH-1:0]   sa;
        logic signed [DATA_WIDTH-1:0]   sb;
        logic signed [2*DATA_WIDTH+1:0] wide;
        logic [DATA_WIDTH:0]            ma;
        logic [DATA_WIDTH:0]            mb;
        logic [DATA_WIDTH:0]            q;
        alu_res_t                       res;
        sa = t.a;
        sb = t.b;
        ma = sa < 0 ? (17'h10000 - {1'b0, t.a}) : {1'b0, t.a};
        mb = sb < 0 ? (17'h10000 - {1'b0, t.b}) : {1'b0, t.b};
        res = '0;
        case (t.op)
            ica_pkg::OP_ADD, ica_pkg::OP_PLUS:
            begin
                wide = sa + sb;
                res.value = wide[DATA_WIDTH-1:0];
                res.err = (t.op == ica_pkg::OP_ADD) && (wide > 32767 || wide < -32768);
            end
            ica_pkg::OP_SUB, ica_pkg::OP_MINUS:
            begin
                wide = sa - sb;
                res.value = wide[DATA_WIDTH-1:0];
                res.err = (t.op == ica_pkg::OP_SUB) && (wide > 32767 || wide < -32768);
            end
            ica_pkg::OP_MUL, ica_pkg::OP_TIMES:
            begin
                wide = sa * sb;
                res.value = wide[DATA_WIDTH-1:0];
                res.err = (t.op == ica_pkg::OP_MUL) && (wide > 32767 || wide < -32768);
            end
            ica_pkg::OP_DIV:
            begin
                if (t.b == '0 || (t.a == 16'h8000 && t.b == 16'hFFFF))
                    res.err = 1'b1;
                else
                begin
                    q = ma / mb;
                    res.value = (sa < 0) != (sb < 0) ? -q[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
                end
            end
            ica_pkg::OP_REM:
            begin
                if (t.b == '0)
                    res.err = 1'b1;
                else if (t.b == 16'h0001 || t.b == 16'hFFFF)
                    res.value = '0;
                else
                begin
                    q = ma % mb;
                    res.value = sa < 0 ? -q[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
                end
            end
            ica_pkg::OP_EQ:   res.value = (t.a == t.b) ? 16'd1 : 16'd0;
            ica_pkg::OP_GT:   res.value = (sa > sb) ? 16'd1 : 16'd0;
            ica_pkg::OP_AND:  res.value = t.a & t.b;
            ica_pkg::OP_OR:   res.value = t.a | t.b;
            ica_pkg::OP_XOR:  res.value = t.a ^ t.b;
            ica_pkg::OP_NOT:  res.value = ~t.a;
            ica_pkg::OP_LSHL: res.value = (t.b > 15) ? '0 : t.a << t.b[3:0];
            default:          res.value = (t.b > 15) ? '0 : t.a >> t.b[3:0];
        endcase
        if (res.err)
            res.value = '0;
        return res;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_operand();
        // bias toward corner values so overflow and divide edges show up often
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return DATA_WIDTH'($urandom_range(0, 20));
            6:       return -DATA_WIDTH'($urandom_range(0, 20));
            7:       return DATA_WIDTH'($urandom_range(0, 255));
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic push_op(ica_pkg::opcode_t op, logic [DATA_WIDTH-1:0] a,
                           logic [DATA_WIDTH-1:0] b);
        alu_op_t t;
        t.op = op;
        t.a = a;
        t.b = b;
        pending_ops.push_back(t);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // driver: falling edge, valid held until the transfer happens
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_done)
            begin
                // previous transfer done (recorded at last rise)
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_axis_tdata  <= {{(IN_BYTES*8-IN_BITS){1'b0}}, pending_ops[0].b,
                                      pending_ops[0].a, pending_ops[0].op};
                    expected_results.push_back(compute_alu(pending_ops.pop_front()));
                    s_axis_tvalid <= 1'b1;
                    ops_sent++;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls and a counted long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        in_done = s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Regression FAIL");
                $finish;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no operation outstanding: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    alu_res_t e;
                    e = expected_results.pop_front();
                    if (m_axis_tdata[DATA_WIDTH-1:0] !== e.value)
                    begin
                        $error("value: expected %h actual %h", e.value,
                               m_axis_tdata[DATA_WIDTH-1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[DATA_WIDTH] !== e.err)
                    begin
                        $error("overflow_error: expected %b actual %b", e.err,
                               m_axis_tdata[DATA_WIDTH]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int phase;
        int k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        in_done = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        errors = 0;
        results_seen = 0;
        ops_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners: overflow edges, divide errors, unit remainders, shifts
        push_op(ica_pkg::OP_ADD,   16'h7FFF, 16'h0001);
        push_op(ica_pkg::OP_ADD,   16'h8000, 16'hFFFF);
        push_op(ica_pkg::OP_PLUS,  16'h7FFF, 16'h0001);
        push_op(ica_pkg::OP_SUB,   16'h8000, 16'h0001);
        push_op(ica_pkg::OP_SUB,   16'h0000, 16'h8000);
        push_op(ica_pkg::OP_MINUS, 16'h8000, 16'h0001);
        push_op(ica_pkg::OP_MUL,   16'h8000, 16'h0001);
        push_op(ica_pkg::OP_MUL,   16'h8000, 16'hFFFF);
        push_op(ica_pkg::OP_MUL,   16'h0100, 16'h0080);
        push_op(ica_pkg::OP_TIMES, 16'h7FFF, 16'h7FFF);
        push_op(ica_pkg::OP_DIV,   16'h1234, 16'h0000);
        push_op(ica_pkg::OP_DIV,   16'h8000, 16'hFFFF);
        push_op(ica_pkg::OP_DIV,   16'hFFF9, 16'h0002);
        push_op(ica_pkg::OP_REM,   16'h0007, 16'h0000);
        push_op(ica_pkg::OP_REM,   16'h8000, 16'hFFFF);
        push_op(ica_pkg::OP_REM,   16'hFFF9, 16'h0002);
        push_op(ica_pkg::OP_EQ,    16'h8000, 16'h8000);
        push_op(ica_pkg::OP_GT,    16'h7FFF, 16'h8000);
        push_op(ica_pkg::OP_AND,   16'hFFFF, 16'hA5A5);
        push_op(ica_pkg::OP_OR,    16'h0000, 16'h5A5A);
        push_op(ica_pkg::OP_XOR,   16'hFFFF, 16'h0F0F);
        push_op(ica_pkg::OP_NOT,   16'h0000, 16'hFFFF);
        push_op(ica_pkg::OP_LSHL,  16'h8001, 16'h0000);
        push_op(ica_pkg::OP_LSHL,  16'h0001, 16'h000F);
        push_op(ica_pkg::OP_LSHR,  16'h8000, 16'hFFFF);
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 35 : 0;
            recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 35 : 0;
            for (k = 0; k < 400; k++)
                push_op(ica_pkg::opcode_t'($urandom_range(0, 15)), rand_operand(),
                        rand_operand());
            if (phase == 0)
            begin
                // long receiver hold while the sender keeps offering
                @(posedge clk);
                hold_cycles = 200;
            end
            wait_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (k = 0; k < 150; k++)
            push_op(ica_pkg::opcode_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
        wait_drained();
        repeat (40) @(posedge clk);

        $display("sent %0d operations over all opcodes and idle phases, checked %0d results",
                 ops_sent, results_seen);
        $display("corners: overflow, zero divisor, min by -1, unit remainder, shift counts");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/ica_pkg.sv
sv/ica_front.sv
sv/ica_queue.sv
sv/ica_back.sv
sv/int16_checked_alu_top.sv
sim/testbench.sv
